@@ design/csl_pkg.sv @@
// Shared types and constants for the C-subset lexer.
// Item layouts, front-to-back op codes, token classes, keyword table.
// No dependencies.
`default_nettype none

package csl_pkg;

  localparam int WORD_MAX_DEF = 32;  // default word buffer depth
  localparam int OP_DEPTH     = 2;   // op queue between front and back
  localparam int RES_DEPTH    = 4;   // result queue depth

  // token classes
  localparam logic [1:0] CLS_KEYWORD = 2'd0;
  localparam logic [1:0] CLS_NUMBER  = 2'd1;
  localparam logic [1:0] CLS_OTHER   = 2'd2;
  localparam logic [1:0] CLS_PUNCT   = 2'd3;

  // characters the scanner cares about
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } csl_in_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic [1:0] token_class;
    logic       last_of_token;
    logic       truncated;
  } csl_out_t;

  // work handed from front to back
  typedef enum logic [2:0] {
    OP_APPEND,      // append ch to the word
    OP_PAIR,        // append '/' then ch
    OP_FLUSH,       // emit pending word
    OP_FLUSH_TOK,   // emit pending word, then one-byte token ch
    OP_SLASH_FLUSH  // append '/', then emit pending word
  } csl_op_kind_t;

  typedef struct packed {
    csl_op_kind_t kind;
    logic [7:0]   ch;
    logic [1:0]   cls;  // class of a one-byte token
  } csl_op_t;

  localparam int KW_NUM = 8;

  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd5, 3'd6, 3'd3, 3'd2, 3'd5, 3'd6, 3'd2};

  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"f", "l", "o", "a",  "t",  8'h0, 8'h0, 8'h0},
    '{"d", "o", "u", "b",  "l",  "e",  8'h0, 8'h0},
    '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"w", "h", "i", "l",  "e",  8'h0, 8'h0, 8'h0},
    '{"s", "w", "i", "t",  "c",  "h",  8'h0, 8'h0},
    '{"d", "o", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };

  // character c at position p still matches keyword k
  function automatic logic kw_hit(input logic [2:0] k, input logic [5:0] p,
                                  input logic [7:0] c);
    return (p < {3'b000, KW_LEN[k]}) && (KW_TEXT[k][p[2:0]] == c);
  endfunction

endpackage

`default_nettype wire

@@ design/csl_fifo.sv @@
// Small synchronous queue, used for the op queue and the result queue.
// Uses nothing from the package.
`default_nettype none

module csl_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire T                           din,
  output logic                            full,
  input  wire logic                       pop,
  output T                                dout,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  T              slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

@@ design/csl_front.sv @@
// Lexer front end: scan-mode tracking per input byte, turns each byte
// into at most one op for the back end. Depends on csl_pkg.
`default_nettype none

module csl_front
  import csl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire csl_in_t byte_item,
  input  wire logic    op_full,
  output logic         op_push,
  output csl_op_t      op
);

  typedef enum logic [2:0] {
    M_NORMAL, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_DIRECTIVE, M_STRING, M_ESCAPE
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic       line_start;
  logic       line_start_next;
  logic       has_op;
  logic       accept;
  logic [7:0] c;
  logic       word_ch;
  logic       punct;
  logic       blank;

  assign c       = byte_item.char_code;
  assign accept  = push && !op_full;
  assign op_push = accept && has_op;

  assign word_ch = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || (c == "_");
  assign punct   = (c == "{") || (c == "}") || (c == "(") || (c == ")") || (c == ";");
  assign blank   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);

  always_comb begin
    mode_next       = mode;
    line_start_next = line_start;
    has_op          = 1'b0;
    op.kind         = OP_FLUSH;
    op.ch           = c;
    op.cls          = punct ? CLS_PUNCT : CLS_OTHER;
    if (byte_item.end_of_input) begin
      has_op          = 1'b1;
      op.kind         = (mode == M_SLASH) ? OP_SLASH_FLUSH : OP_FLUSH;
      mode_next       = M_NORMAL;
      line_start_next = 1'b1;
    end else begin
      case (mode)
        M_SLASH: begin
          has_op = 1'b1;
          if (c == CH_SLASH) begin
            op.kind   = OP_FLUSH;
            mode_next = M_LINE;
          end else if (c == CH_STAR) begin
            op.kind   = OP_FLUSH;
            mode_next = M_BLOCK;
          end else begin
            op.kind         = OP_PAIR;
            line_start_next = 1'b0;
            mode_next       = M_NORMAL;
          end
        end
        M_LINE, M_DIRECTIVE: begin
          if (c == CH_NL) begin
            line_start_next = 1'b1;
            mode_next       = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (c == CH_STAR) mode_next = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == CH_SLASH) mode_next = M_NORMAL;
          else if (c != CH_STAR) mode_next = M_BLOCK;
        end
        M_STRING: begin
          if (c == CH_BSLASH) mode_next = M_ESCAPE;
          else if (c == CH_QUOTE) mode_next = M_NORMAL;
        end
        M_ESCAPE: begin
          mode_next = M_STRING;
        end
        M_NORMAL: begin
          if (c == CH_SLASH) begin
            mode_next = M_SLASH;
          end else if (c == CH_HASH && line_start) begin
            has_op    = 1'b1;
            op.kind   = OP_FLUSH;
            mode_next = M_DIRECTIVE;
          end else if (c == CH_QUOTE) begin
            has_op    = 1'b1;
            op.kind   = OP_FLUSH;
            mode_next = M_STRING;
          end else if (word_ch) begin
            has_op          = 1'b1;
            op.kind         = OP_APPEND;
            line_start_next = 1'b0;
          end else begin
            has_op  = 1'b1;
            op.kind = blank ? OP_FLUSH : OP_FLUSH_TOK;
            if (c == CH_NL) line_start_next = 1'b1;
          end
        end
        default: begin
          mode_next = M_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      line_start <= 1'b1;
    end else if (accept) begin
      mode       <= mode_next;
      line_start <= line_start_next;
    end
  end

endmodule

`default_nettype wire

@@ design/csl_back.sv @@
// Lexer back end: word store, incremental keyword/number matching and
// per-character emission into the result queue. Depends on csl_pkg.
`default_nettype none

module csl_back
  import csl_pkg::*;
#(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire csl_op_t                        op,
  input  wire logic                           op_empty,
  output logic                                op_pop,
  input  wire logic [$clog2(RES_DEPTH+1)-1:0] res_count,
  output logic                                res_push,
  output csl_out_t                            res_item
);

  localparam int AW = $clog2(WORD_MAX);
  localparam int LW = $clog2(WORD_MAX+1);
  localparam int CW = $clog2(RES_DEPTH+1);

  typedef enum logic [2:0] {
    S_IDLE, S_PAIR2, S_CLASS, S_READ, S_LAST, S_TOKEN
  } state_t;

  state_t              state;
  logic [7:0]          mem [WORD_MAX];
  logic [LW-1:0]       len;
  logic                ovf;
  logic [KW_NUM-1:0]   kw_ok;
  logic [KW_NUM-1:0]   kw_ok_next;
  logic [KW_NUM-1:0]   kw_full;
  logic                all_dig;
  logic [LW-1:0]       rd_idx;
  logic                rd_pend;
  logic                rd_last;
  logic [7:0]          rdata;
  logic [1:0]          cls;
  logic [1:0]          cls_next;
  logic                tok_pend;
  logic [7:0]          tok_ch;
  logic [1:0]          tok_cls;
  logic [7:0]          pair_ch;
  logic                app_en;
  logic [7:0]          app_ch;
  logic                app_room;
  logic                rd_issue;
  logic                rd_is_last;
  logic                tok_wr;
  logic                space;

  // room in the result queue, counting the read still in flight
  assign space      = ({1'b0, res_count} + (CW+1)'(rd_pend)) < (CW+1)'(RES_DEPTH);
  assign app_room   = (len < LW'(WORD_MAX));
  assign rd_is_last = (rd_idx == len - LW'(1));

  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      kw_ok_next[k] = kw_ok[k] && kw_hit(3'(k), 6'(len), app_ch);
      kw_full[k]    = kw_ok[k] && (len == LW'(KW_LEN[k]));
    end
    if (|kw_full) cls_next = CLS_KEYWORD;
    else if (all_dig) cls_next = CLS_NUMBER;
    else cls_next = CLS_OTHER;
  end

  always_comb begin
    op_pop   = 1'b0;
    app_en   = 1'b0;
    app_ch   = op.ch;
    rd_issue = 1'b0;
    tok_wr   = 1'b0;
    case (state)
      S_IDLE: begin
        op_pop = !op_empty;
        if (!op_empty) begin
          case (op.kind)
            OP_APPEND: begin
              app_en = 1'b1;
            end
            OP_PAIR, OP_SLASH_FLUSH: begin
              app_en = 1'b1;
              app_ch = CH_SLASH;
            end
            default: begin
              app_en = 1'b0;
            end
          endcase
        end
      end
      S_PAIR2: begin
        app_en = 1'b1;
        app_ch = pair_ch;
      end
      S_READ:  rd_issue = space;
      S_TOKEN: tok_wr   = space;
      default: begin
        app_en = 1'b0;
      end
    endcase
  end

  // result mux: word character arriving from the store, or a one-byte token
  assign res_push = rd_pend || tok_wr;
  always_comb begin
    if (rd_pend) begin
      res_item.token_char    = rdata;
      res_item.token_class   = cls;
      res_item.last_of_token = rd_last;
      res_item.truncated     = ovf;
    end else begin
      res_item.token_char    = tok_ch;
      res_item.token_class   = tok_cls;
      res_item.last_of_token = 1'b1;
      res_item.truncated     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (app_en && app_room) begin
      mem[len[AW-1:0]] <= app_ch;
    end
    if (rd_issue) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      ovf      <= 1'b0;
      kw_ok    <= '1;
      all_dig  <= 1'b1;
      rd_pend  <= 1'b0;
      tok_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (app_en) begin
        if (app_room) begin
          len     <= len + LW'(1);
          kw_ok   <= kw_ok_next;
          all_dig <= all_dig && (app_ch >= "0") && (app_ch <= "9");
        end else begin
          ovf <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (!op_empty) begin
            tok_ch  <= op.ch;
            tok_cls <= op.cls;
            pair_ch <= op.ch;
            case (op.kind)
              OP_PAIR: state <= S_PAIR2;
              OP_FLUSH, OP_SLASH_FLUSH: begin
                tok_pend <= 1'b0;
                state    <= S_CLASS;
              end
              OP_FLUSH_TOK: begin
                tok_pend <= 1'b1;
                state    <= S_CLASS;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PAIR2: state <= S_IDLE;
        S_CLASS: begin
          cls    <= cls_next;
          rd_idx <= '0;
          if (len == '0) state <= tok_pend ? S_TOKEN : S_IDLE;
          else state <= S_READ;
        end
        S_READ: begin
          if (rd_issue) begin
            rd_idx  <= rd_idx + LW'(1);
            rd_last <= rd_is_last;
            if (rd_is_last) state <= S_LAST;
          end
        end
        S_LAST: begin
          // final character goes out this cycle; start a fresh word
          len     <= '0;
          ovf     <= 1'b0;
          kw_ok   <= '1;
          all_dig <= 1'b1;
          state   <= tok_pend ? S_TOKEN : S_IDLE;
        end
        S_TOKEN: begin
          if (tok_wr) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/c_subset_lexer.sv @@
// Byte-serial tokenizer for a small C subset: top level.
// Depends on csl_pkg, csl_front, csl_back, csl_fifo.
//
// Input channel (push/full): one item per source byte, or an end_of_input
// item that flushes the pending word and returns the scanner to reset state.
// Result channel (empty/pop): one item per token character, oldest first,
// with its class, a last-of-token mark and a truncated mark.
//
// The front end classifies a byte in the cycle it is accepted and drops at
// most one op into a 2-entry op queue, so it takes one byte per cycle until
// that queue fills. The back end sets the sustained pace: it appends a word
// character in S_IDLE, takes a lone '/' pair through S_IDLE and S_PAIR2,
// and runs a flush through S_CLASS, one S_READ step per word character and
// S_LAST (S_CLASS alone for an empty word), then S_TOKEN for a trailing
// one-byte token, and pops no new op until it is back in S_IDLE. The word
// store delivers one character per cycle through its single read port
// while the result queue has room, via a registered read.
//
// Reset (rst, synchronous) clears scan mode, word length and both queues; the
// word store itself is not cleared. When pop is held low the 4-entry result
// queue fills, the back end stops, the op queue fills and full rises; nothing
// is lost.
`default_nettype none

module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire csl_in_t byte_item,
  output logic         full,
  input  wire logic    pop,
  output csl_out_t     token_item,
  output logic         empty
);

  localparam int RCW = $clog2(RES_DEPTH+1);

  csl_op_t        op_in;
  csl_op_t        op_out;
  logic           op_push;
  logic           op_pop;
  logic           op_full;
  logic           op_empty;
  logic           res_push;
  csl_out_t       res_item;
  logic [RCW-1:0] res_count;

  // a byte is taken whenever the op queue has room, even if it yields no op
  assign full = op_full;

  csl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .byte_item (byte_item),
    .op_full   (op_full),
    .op_push   (op_push),
    .op        (op_in)
  );

  csl_fifo #(.T(csl_op_t), .DEPTH(OP_DEPTH)) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .din   (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .dout  (op_out),
    .empty (op_empty),
    .count ()
  );

  csl_back #(.WORD_MAX(WORD_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (op_out),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // back end only pushes when it has counted room, so full is not needed
  csl_fifo #(.T(csl_out_t), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_item),
    .full  (),
    .pop   (pop),
    .dout  (token_item),
    .empty (empty),
    .count (res_count)
  );

endmodule

`default_nettype wire

@@ dv/csl_tb_pkg.sv @@
// Scoreboard for the C-subset lexer testbench: token predictor and result check.
// Depends on csl_pkg for the item layouts, token classes and character codes.
package csl_tb_pkg;
  import csl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_SLASH,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_BSTAR,
    SCAN_DIRECTIVE,
    SCAN_STRING,
    SCAN_ESCAPE
  } scan_mode_e;

  function automatic string keyword_text(int k);
    case (k)
      0: return "int";
      1: return "float";
      2: return "double";
      3: return "for";
      4: return "if";
      5: return "while";
      6: return "switch";
      default: return "do";
    endcase
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == "{" || c == "}" || c == "(" || c == ")" || c == ";";
  endfunction

  class token_scoreboard;
    csl_out_t   due_tokens[$];
    logic [7:0] held[WORD_MAX_DEF];
    int         held_len;
    bit         clipped;
    scan_mode_e mode;
    bit         line_start;
    int         mismatches;
    int         tokens_checked;
    int         clipped_tokens;

    function new();
      mismatches     = 0;
      tokens_checked = 0;
      clipped_tokens = 0;
      clear_state();
    endfunction

    function void clear_state();
      held_len   = 0;
      clipped    = 0;
      mode       = SCAN_NORMAL;
      line_start = 1;
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    function void add_char(logic [7:0] c);
      if (held_len < WORD_MAX_DEF) begin
        held[held_len] = c;
        held_len++;
      end else begin
        clipped = 1;
      end
    endfunction

    function logic [1:0] word_class();
      string kw;
      bit    same;
      bit    digits;
      for (int k = 0; k < 8; k++) begin
        kw = keyword_text(k);
        if (kw.len() == held_len) begin
          same = 1;
          for (int i = 0; i < held_len; i++)
            if (held[i] != kw[i]) same = 0;
          if (same) return CLS_KEYWORD;
        end
      end
      if (held_len == 1 && is_punct(held[0])) return CLS_PUNCT;
      digits = 1;
      for (int i = 0; i < held_len; i++)
        if (held[i] < "0" || held[i] > "9") digits = 0;
      return digits ? CLS_NUMBER : CLS_OTHER;
    endfunction

    function void queue_token(logic [7:0] c, logic [1:0] cls, bit last, bit trunc);
      csl_out_t t;
      t.token_char    = c;
      t.token_class   = cls;
      t.last_of_token = last;
      t.truncated     = trunc;
      if (trunc) clipped_tokens++;
      due_tokens.push_back(t);
    endfunction

    function void emit_word();
      logic [1:0] cls;
      if (held_len == 0) return;
      cls = word_class();
      for (int k = 0; k < held_len; k++)
        queue_token(held[k], cls, k == held_len - 1, clipped);
      held_len = 0;
      clipped  = 0;
    endfunction

    function void note_byte(csl_in_t it);
      logic [7:0] c;
      logic [1:0] cls;
      c = it.char_code;
      if (it.end_of_input) begin
        if (mode == SCAN_SLASH) add_char(CH_SLASH);
        emit_word();
        clear_state();
        return;
      end
      case (mode)
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            emit_word();
            mode = SCAN_LINE;
          end else if (c == CH_STAR) begin
            emit_word();
            mode = SCAN_BLOCK;
          end else begin
            add_char(CH_SLASH);
            add_char(c);
            line_start = 0;
            mode = SCAN_NORMAL;
          end
        end
        SCAN_LINE, SCAN_DIRECTIVE: begin
          if (c == CH_NL) begin
            line_start = 1;
            mode = SCAN_NORMAL;
          end
        end
        SCAN_BLOCK: begin
          if (c == CH_STAR) mode = SCAN_BSTAR;
        end
        SCAN_BSTAR: begin
          if (c == CH_SLASH) mode = SCAN_NORMAL;
          else if (c != CH_STAR) mode = SCAN_BLOCK;
        end
        SCAN_STRING: begin
          if (c == CH_BSLASH) mode = SCAN_ESCAPE;
          else if (c == CH_QUOTE) mode = SCAN_NORMAL;
        end
        SCAN_ESCAPE: begin
          mode = SCAN_STRING;
        end
        default: begin
          if (c == CH_SLASH) begin
            mode = SCAN_SLASH;
          end else if (c == CH_HASH && line_start) begin
            emit_word();
            mode = SCAN_DIRECTIVE;
          end else if (c == CH_QUOTE) begin
            emit_word();
            mode = SCAN_STRING;
          end else if (is_word_char(c)) begin
            add_char(c);
            line_start = 0;
          end else begin
            emit_word();
            if (c != CH_SPACE && c != CH_TAB && c != CH_NL) begin
              if (is_punct(c)) cls = CLS_PUNCT;
              else if (c >= "0" && c <= "9") cls = CLS_NUMBER;
              else cls = CLS_OTHER;
              queue_token(c, cls, 1, 0);
            end
            if (c == CH_NL) line_start = 1;
          end
        end
      endcase
    endfunction

    function void check_token(csl_out_t got);
      csl_out_t want;
      if (due_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token item: char %h class %0d last %0b trunc %0b",
                   got.token_char, got.token_class, got.last_of_token, got.truncated);
        return;
      end
      want = due_tokens.pop_front();
      tokens_checked++;
      if (got.token_char !== want.token_char || got.token_class !== want.token_class ||
          got.last_of_token !== want.last_of_token || got.truncated !== want.truncated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d mismatch: want char %h class %0d last %0b trunc %0b, got char %h class %0d last %0b trunc %0b",
                   tokens_checked, want.token_char, want.token_class, want.last_of_token,
                   want.truncated, got.token_char, got.token_class, got.last_of_token,
                   got.truncated);
      end
    endfunction
  endclass

endpackage

@@ dv/tb.sv @@
// Top-level testbench for c_subset_lexer: clock, reset, source byte driver,
// token receiver and final verdict. Depends on csl_pkg and csl_tb_pkg.
module tb;
  import csl_pkg::*;
  import csl_tb_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  csl_in_t  byte_item = '0;
  logic     full;
  logic     pop = 1'b0;
  csl_out_t token_item;
  logic     empty;

  // No new idling starts on either side once this is set (tail of the run).
  bit calm = 0;

  token_scoreboard sb;
  csl_in_t         src_q[$];
  int              eoi_items = 0;

  c_subset_lexer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .byte_item (byte_item),
    .full      (full),
    .pop       (pop),
    .token_item(token_item),
    .empty     (empty)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Source text builders. Everything goes into src_q, then gets driven in order.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] c);
    csl_in_t it;
    it.char_code    = c;
    it.end_of_input = 1'b0;
    src_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // end_of_input item; char_code is don't-care, so randomize it
  function automatic void add_end();
    csl_in_t it;
    it.char_code    = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    src_q.push_back(it);
    eoi_items++;
  endfunction

  function automatic logic [7:0] pick_word_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_non_nl();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
    return c;
  endfunction

  // One random lexical piece. Mostly well-formed constructs with random
  // content, with some raw noise and stray end_of_input items mixed in.
  function automatic void add_random_piece();
    int         pick;
    int         n;
    string      kw;
    string      pool;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      add_text(keyword_text($urandom_range(0, 7)));
    end else if (pick < 18) begin
      // near misses: keyword with one char more or one less
      kw = keyword_text($urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
        add_text(kw);
        add_byte(pick_word_char());
      end else begin
        add_text(kw.substr(0, kw.len() - 2));
      end
    end else if (pick < 30) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(pick_word_char());
    end else if (pick < 39) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 49) begin
      pool = "{}();";
      add_byte(pool[$urandom_range(0, 4)]);
    end else if (pick < 58) begin
      pool = " \t\n";
      add_byte(pool[$urandom_range(0, 2)]);
    end else if (pick < 62) begin
      add_text("//");
      n = $urandom_range(0, 6);
      repeat (n) add_byte(pick_non_nl());
      add_byte(CH_NL);
    end else if (pick < 66) begin
      // block comment; stray '*' and '/' inside exercise the after-star state
      add_text("/*");
      pool = "ab */\n**";
      n = $urandom_range(0, 6);
      repeat (n) add_byte(pool[$urandom_range(0, pool.len() - 1)]);
      add_text("*/");
    end else if (pick < 70) begin
      add_byte(CH_QUOTE);
      pool = "ab /*#\t\\";
      n = $urandom_range(0, 6);
      repeat (n) begin
        c = pool[$urandom_range(0, pool.len() - 1)];
        add_byte(c);
        if (c == CH_BSLASH) add_byte(8'($urandom_range(0, 255)));
      end
      add_byte(CH_QUOTE);
    end else if (pick < 74) begin
      add_byte(CH_NL);
      add_byte(CH_HASH);
      n = $urandom_range(0, 5);
      repeat (n) add_byte(pick_non_nl());
      add_byte(CH_NL);
    end else if (pick < 80) begin
      // lone slash: partner is any byte but the two comment openers
      add_byte(CH_SLASH);
      do c = 8'($urandom_range(0, 255)); while (c == CH_SLASH || c == CH_STAR);
      add_byte(c);
    end else if (pick < 84) begin
      do c = 8'($urandom_range(33, 126));
      while (is_word_char(c) || c == CH_SLASH || c == CH_QUOTE);
      add_byte(c);
    end else if (pick < 88) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 91) begin
      add_end();
    end else if (pick < 94) begin
      // overlong word, sometimes all digits
      n = $urandom_range(WORD_MAX_DEF + 1, WORD_MAX_DEF + 8);
      if ($urandom_range(0, 1)) repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
      else repeat (n) add_byte(pick_word_char());
    end else begin
      add_byte(pick_word_char());
      add_byte(CH_SLASH);
      add_byte(pick_word_char());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present one item on the falling edge, hold it until accepted.
  // ---------------------------------------------------------------------------
  task automatic send_byte(csl_in_t it);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push      <= 1'b1;
    byte_item <= it;
    // accepted on the first rising edge with full low
    while (1) begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_byte(it);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop with random stall bursts, check on each accepted result.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) sb.check_token(token_item);
    end
  end

  // Watchdog, sized for a slow run: every item waits out the longest gap and
  // every result the longest stall, with plenty of margin on top.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text: keyword, number, punctuation, empty block comment,
    // identifier, line comment, directive at line start, lone slash pair,
    // string with an escaped quote, hash mid-line, byte extremes, then a
    // word ending in a slash still waiting for its partner at end of input.
    add_text("int 42{/**/x//c\n#z\n/;\"\\\"\"#");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_end();
    add_text("q/");
    add_end();

    while (src_q.size() < 380) add_random_piece();
    add_end();

    for (int i = 0; i < src_q.size(); i++) begin
      calm = (i >= src_q.size() - 60);
      send_byte(src_q[i]);
    end
    @(negedge clk);
    push <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    // let anything stray drain out and get flagged
    repeat (40) @(posedge clk);

    $display("covered %0d source items (%0d end-of-input), %0d token items checked",
             src_q.size(), eoi_items, sb.tokens_checked);
    $display("%0d token items carried the truncated mark", sb.clipped_tokens);
    if (sb.pending() > 0) $display("%0d token items never arrived", sb.pending());
    if (sb.mismatches > 0) $display("%0d token mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
